[sv/lptd_pkg.sv]
// Shared types and constants for the length-prefixed text deframer.
package lptd_pkg;

  localparam int TEXT_CAPACITY_DEF = 31;
  // Stored length and character count; wide enough for capacities up to 63.
  localparam int CNT_W = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_CONSUME = 1'b1;

  // Register index taken from paddr[2].
  localparam logic REG_SIGNATURE = 1'b0;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_NONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_LOAD = 2'd2
  } back_state_t;

  // One queued job for the back end.
  typedef struct packed {
    kind_t             kind;
    logic [CNT_W-1:0]  count;
    logic              packet_done;
    logic              message_ready;
    logic [31:0]       packets_seen;
  } entry_t;

endpackage

[sv/lptd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lptd_queue.sv]
// Short FIFO of jobs between the front and back ends.
module lptd_queue import lptd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  entry_t         slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;

  assign full      = (fill == (QAW+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    ptr_inc = (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[sv/lptd_front.sv]
// Front end: accepts input transactions, parses packets, fills the text store.
module lptd_front import lptd_pkg::*; #(
  parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF,
  localparam int AW = (TEXT_CAPACITY > 1) ? $clog2(TEXT_CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    signature_byte,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          func,
  input  logic [7:0]    data_byte,
  input  logic          q_full,
  output logic          q_push,
  output entry_t        q_entry,
  input  logic          consume_done,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata
);

  localparam logic [7:0]       CAP8  = 8'(TEXT_CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(TEXT_CAPACITY);

  phase_t           phase, phase_next;
  logic [7:0]       expected_length, expected_length_next;
  logic [7:0]       write_position, write_position_next;
  logic [CNT_W-1:0] stored_length, stored_length_next;
  logic             ready_flag, ready_flag_next;
  logic [31:0]      packet_counter, packet_counter_next;
  logic             busy, busy_next;

  logic             accept;
  logic             is_byte;
  logic [7:0]       wp_inc;
  logic             data_complete;
  logic             length_ends;

  // Hold input while the queue is full or a consume still reads the store.
  assign in_stall = q_full | busy;
  assign accept   = in_valid & ~in_stall;
  assign is_byte  = (func == FUNC_BYTE);

  assign wp_inc        = (write_position != 8'hFF) ? write_position + 8'd1 : write_position;
  assign data_complete = (wp_inc >= expected_length);
  assign length_ends   = (data_byte == 8'd0) | ready_flag;

  // Phase transitions.
  always_comb begin
    phase_next = phase;
    if (accept && is_byte) begin
      case (phase)
        PH_LENGTH: phase_next = length_ends ? PH_HUNT : PH_DATA;
        PH_DATA:   phase_next = data_complete ? PH_HUNT : PH_DATA;
        default:   phase_next = (data_byte == signature_byte) ? PH_LENGTH : PH_HUNT;
      endcase
    end
  end

  // Datapath and queue entry.
  always_comb begin
    expected_length_next = expected_length;
    write_position_next  = write_position;
    stored_length_next   = stored_length;
    ready_flag_next      = ready_flag;
    packet_counter_next  = packet_counter;
    busy_next            = busy & ~consume_done;
    ram_we               = 1'b0;
    ram_waddr            = write_position[AW-1:0];
    ram_wdata            = data_byte;
    q_push               = accept;
    q_entry.kind         = KIND_STATUS;
    q_entry.count        = stored_length;
    q_entry.packet_done  = 1'b0;

    if (accept) begin
      if (!is_byte) begin
        ready_flag_next = 1'b0;
        if (ready_flag && (stored_length != '0)) begin
          q_entry.kind = KIND_TEXT;
          busy_next    = 1'b1;
        end else begin
          q_entry.kind = KIND_NONE;
        end
      end else begin
        case (phase)
          PH_LENGTH: begin
            if (length_ends) begin
              packet_counter_next = packet_counter + 32'd1;
              q_entry.packet_done = 1'b1;
            end else begin
              expected_length_next = data_byte;
              write_position_next  = 8'd0;
            end
          end
          PH_DATA: begin
            ram_we              = (write_position < CAP8);
            write_position_next = wp_inc;
            if (data_complete) begin
              stored_length_next  = (wp_inc > CAP8) ? CAP_C : wp_inc[CNT_W-1:0];
              ready_flag_next     = 1'b1;
              packet_counter_next = packet_counter + 32'd1;
              q_entry.packet_done = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
    q_entry.message_ready = ready_flag_next;
    q_entry.packets_seen  = packet_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      expected_length <= '0;
      write_position  <= '0;
      stored_length   <= '0;
      ready_flag      <= 1'b0;
      packet_counter  <= '0;
      busy            <= 1'b0;
    end else begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      write_position  <= write_position_next;
      stored_length   <= stored_length_next;
      ready_flag      <= ready_flag_next;
      packet_counter  <= packet_counter_next;
      busy            <= busy_next;
    end
  end

endmodule

[sv/lptd_back.sv]
// Back end: drains queued jobs and streams results through the output register.
module lptd_back import lptd_pkg::*; #(
  parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF,
  localparam int AW = (TEXT_CAPACITY > 1) ? $clog2(TEXT_CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  entry_t        q_head,
  output logic          q_pop,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output logic          consume_done,
  output logic          out_valid,
  input  logic          out_stall,
  output kind_t         out_kind,
  output logic [7:0]    out_char,
  output logic          out_last,
  output logic          out_done,
  output logic          out_ready,
  output logic [31:0]   out_seen
);

  back_state_t      state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [31:0]      seen, seen_next;
  logic             out_valid_next;
  kind_t            out_kind_next;
  logic [7:0]       out_char_next;
  logic             out_last_next;
  logic             out_done_next;
  logic             out_ready_next;
  logic [31:0]      out_seen_next;

  logic             out_free;
  logic [CNT_W-1:0] idx_inc;
  logic             is_last_char;

  assign out_free     = ~out_valid | ~out_stall;
  assign idx_inc      = idx + 1'b1;
  assign is_last_char = (idx_inc == cnt);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_not_empty && out_free && (q_head.kind == KIND_TEXT)) begin
          state_next = B_LOAD;
        end
      end
      B_READ: begin
        if (out_free) begin
          state_next = B_LOAD;
        end
      end
      B_LOAD:  state_next = is_last_char ? B_IDLE : B_READ;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop          = 1'b0;
    ram_raddr      = idx[AW-1:0];
    consume_done   = 1'b0;
    idx_next       = idx;
    cnt_next       = cnt;
    seen_next      = seen;
    // Drop the output once it has been taken.
    out_valid_next = out_valid & out_stall;
    out_kind_next  = out_kind;
    out_char_next  = out_char;
    out_last_next  = out_last;
    out_done_next  = out_done;
    out_ready_next = out_ready;
    out_seen_next  = out_seen;
    case (state)
      B_IDLE: begin
        if (q_not_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.kind == KIND_TEXT) begin
            ram_raddr = '0;
            idx_next  = '0;
            cnt_next  = q_head.count;
            seen_next = q_head.packets_seen;
          end else begin
            out_valid_next = 1'b1;
            out_kind_next  = q_head.kind;
            out_char_next  = 8'd0;
            out_last_next  = 1'b1;
            out_done_next  = q_head.packet_done;
            out_ready_next = q_head.message_ready;
            out_seen_next  = q_head.packets_seen;
          end
        end
      end
      B_LOAD: begin
        out_valid_next = 1'b1;
        out_kind_next  = KIND_TEXT;
        out_char_next  = ram_rdata;
        out_last_next  = is_last_char;
        out_done_next  = 1'b0;
        out_ready_next = 1'b0;
        out_seen_next  = seen;
        idx_next       = idx_inc;
        consume_done   = is_last_char;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    cnt       <= cnt_next;
    seen      <= seen_next;
    out_kind  <= out_kind_next;
    out_char  <= out_char_next;
    out_last  <= out_last_next;
    out_done  <= out_done_next;
    out_ready <= out_ready_next;
    out_seen  <= out_seen_next;
  end

endmodule

[sv/length_prefixed_text_deframer_top.sv]
// Top level of the length-prefixed text deframer.
//
// Input channel (in_valid / in_stall): func selects a received serial byte
// (data_byte) or a consume of the pending text message. Output channel
// (out_valid / out_stall): one status result per serial byte; a consume gives
// one text character per result, or a single "no message" result.
// A byte transaction's result passes through the job queue and then the output
// register; one byte can be accepted every cycle, limited only by a pending
// consume, the two-entry job queue and the output register.
// A consume streams its characters through the read and load states in turn,
// as the read of the text RAM is registered; input is held stalled from the
// consume until its last character has entered the output register.
// When the receiver stalls, the output register holds, the queue fills and
// in_stall rises.
// Reset clears the parser to hunting, the ready flag, the packet counter and
// the signature register; the text RAM is not cleared.
// The signature register sits at APB address 0 and may be read back.
module length_prefixed_text_deframer_top import lptd_pkg::*; #(
  parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  text_char,
  output logic        last,
  output logic        packet_done,
  output logic        message_ready,
  output logic [31:0] packets_seen
);

  localparam int AW = (TEXT_CAPACITY > 1) ? $clog2(TEXT_CAPACITY) : 1;

  logic [7:0]    signature_byte;
  logic          q_push, q_pop, q_full, q_not_empty;
  entry_t        q_entry, q_head;
  logic          consume_done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  kind_t         out_kind;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIGNATURE) ? {24'd0, signature_byte} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      signature_byte <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SIGNATURE)) begin
      signature_byte <= pwdata[7:0];
    end
  end

  lptd_front #(
    .TEXT_CAPACITY(TEXT_CAPACITY)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .signature_byte(signature_byte),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .data_byte     (data_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry),
    .consume_done  (consume_done),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  lptd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lptd_ram #(
    .WIDTH(8),
    .DEPTH(TEXT_CAPACITY)
  ) u_text_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lptd_back #(
    .TEXT_CAPACITY(TEXT_CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .consume_done(consume_done),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_char    (text_char),
    .out_last    (last),
    .out_done    (packet_done),
    .out_ready   (message_ready),
    .out_seen    (packets_seen)
  );

  assign kind = out_kind;

endmodule
